// ===== hw/rtl/gmp_pkg.sv =====
// Shared constants and types for the grid maximum path block.
package gmp_pkg;

    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_MAX_COLS  = 1024;
    localparam int DEF_CELL_BITS = 16;

    localparam int TOTAL_W    = 26;
    localparam int ROWS_CFG_W = 7;
    localparam int COLS_CFG_W = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

    typedef struct packed {
        logic first_col;
        logic top_row;
        logic last_row;
        logic last_col;
    } cell_pos_t;

endpackage

// ===== hw/rtl/grid_max_path_dp.sv =====
// Top level of the grid maximum path block: streaming column-by-column path search.
//
// Cells arrive on the s_ channel (valid/ready), column by column, top row first.
// Each cell's total is its value plus the largest of the previous column's totals
// in the rows above, level with and below it. After the last cell of the last
// column, one item carrying the largest total of that column leaves on the m_
// channel (valid/ready). Grid size comes from rows_in_use and cols_in_use,
// written over the cfg_ port, which is always ready.
//
// One cell is taken every cycle. An accepted cell is looked up in the column
// store as it enters the second stage and finished from that stage, which
// writes the result item into the output register. The stored column is
// a single-write, dual-read memory; a write to the row being read is forwarded.
// If the receiver stalls, cells keep flowing until the next grid-ending cell,
// which waits in the second stage until the output register is free; s_ready
// then drops. Reset clears the counters, the running totals and the valid
// flags of both stages and sets both sizes to one; the column store is not cleared.
module grid_max_path_dp #(
    parameter int MAX_ROWS  = gmp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = gmp_pkg::DEF_MAX_COLS,
    parameter int CELL_BITS = gmp_pkg::DEF_CELL_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [CELL_BITS-1:0]           s_cell_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [gmp_pkg::TOTAL_W-1:0]    m_best_total,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gmp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gmp_pkg::*;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SUM_W = ((CELL_BITS > TOTAL_W) ? CELL_BITS : TOTAL_W) + 1;

    // Configuration registers
    logic [ROWS_CFG_W-1:0] rows_cfg_reg;
    logic [COLS_CFG_W-1:0] cols_cfg_reg;

    // Position counters
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;

    // Second stage
    logic                 s1_valid_reg, s1_valid_next;
    logic [CELL_BITS-1:0] s1_cell_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    cell_pos_t            s1_pos_reg, pos_next;
    logic [TOTAL_W-1:0]   mid_reg, down_reg;

    logic [TOTAL_W-1:0] held_reg, held_next;
    logic [TOTAL_W-1:0] best_reg, best_next;

    logic               m_valid_reg, m_valid_next;
    logic [TOTAL_W-1:0] m_best_reg, m_best_next;

    logic [TOTAL_W-1:0] col_mem [MAX_ROWS];

    int               rows_m1_i, cols_m1_i;
    logic [ROW_W-1:0] rows_m1, row_eff, row_dn;
    logic [COL_W-1:0] cols_m1, col_eff;

    logic               accept, s1_fire, grid_end;
    logic [TOTAL_W-1:0] up_val, down_val, nb_max, total, best_cand;
    logic [SUM_W-1:0]   sum_wide;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= ROWS_CFG_W'(1);
            cols_cfg_reg <= COLS_CFG_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROWS_IN_USE: rows_cfg_reg <= cfg_data[ROWS_CFG_W-1:0];
                REG_COLS_IN_USE: cols_cfg_reg <= cfg_data[COLS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero acts as one, values above the maximum saturate there.
    always_comb begin
        if (rows_cfg_reg == '0) begin
            rows_m1_i = 0;
        end else if (int'(rows_cfg_reg) > MAX_ROWS) begin
            rows_m1_i = MAX_ROWS - 1;
        end else begin
            rows_m1_i = int'(rows_cfg_reg) - 1;
        end
        if (cols_cfg_reg == '0) begin
            cols_m1_i = 0;
        end else if (int'(cols_cfg_reg) > MAX_COLS) begin
            cols_m1_i = MAX_COLS - 1;
        end else begin
            cols_m1_i = int'(cols_cfg_reg) - 1;
        end
        rows_m1 = ROW_W'(rows_m1_i);
        cols_m1 = COL_W'(cols_m1_i);
    end

    // A counter at or beyond the last position is taken as being at it.
    always_comb begin
        row_eff = (row_cnt_reg >= rows_m1) ? rows_m1 : row_cnt_reg;
        col_eff = (col_cnt_reg >= cols_m1) ? cols_m1 : col_cnt_reg;
        row_dn  = row_eff + ROW_W'(1);
        pos_next.first_col = (col_eff == '0);
        pos_next.top_row   = (row_eff == '0);
        pos_next.last_row  = (row_eff == rows_m1);
        pos_next.last_col  = (col_eff == cols_m1);
    end

    // Second stage arithmetic
    always_comb begin
        up_val    = s1_pos_reg.top_row ? '0 : held_reg;
        down_val  = s1_pos_reg.last_row ? '0 : down_reg;
        nb_max    = (up_val > mid_reg) ? up_val : mid_reg;
        nb_max    = (down_val > nb_max) ? down_val : nb_max;
        if (s1_pos_reg.first_col) begin
            sum_wide = SUM_W'(s1_cell_reg);
        end else begin
            sum_wide = SUM_W'(s1_cell_reg) + SUM_W'(nb_max);
        end
        total     = sum_wide[TOTAL_W-1:0];
        best_cand = (total > best_reg) ? total : best_reg;
    end

    // A grid-ending item may only finish when the output register is free.
    assign grid_end = s1_pos_reg.last_row && s1_pos_reg.last_col;
    assign s1_fire  = s1_valid_reg && !(grid_end && m_valid_reg && !m_ready);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign accept   = s_valid && s_ready;

    always_comb begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (accept) begin
            if (pos_next.last_row && pos_next.last_col) begin
                row_cnt_next = '0;
                col_cnt_next = '0;
            end else if (pos_next.last_row) begin
                row_cnt_next = '0;
                col_cnt_next = col_eff + COL_W'(1);
            end else begin
                row_cnt_next = row_dn;
            end
        end

        s1_valid_next = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

        held_next    = held_reg;
        best_next    = best_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        m_best_next  = m_best_reg;
        if (s1_fire) begin
            if (grid_end) begin
                held_next    = '0;
                best_next    = '0;
                m_valid_next = 1'b1;
                m_best_next  = best_cand;
            end else begin
                held_next = mid_reg;
                if (s1_pos_reg.last_col) begin
                    best_next = best_cand;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            held_reg     <= '0;
            best_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
            s1_valid_reg <= s1_valid_next;
            held_reg     <= held_next;
            best_reg     <= best_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_best_reg <= m_best_next;
        if (accept) begin
            s1_cell_reg <= s_cell_value;
            s1_row_reg  <= row_eff;
            s1_pos_reg  <= pos_next;
        end
    end

    // Column store: written by the finishing stage, read at accept. The row just
    // being written is forwarded so a short column sees the previous column's new totals.
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            col_mem[s1_row_reg] <= total;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (s1_fire && (s1_row_reg == row_eff)) begin
                mid_reg <= total;
            end else begin
                mid_reg <= col_mem[row_eff];
            end
            if (s1_fire && (s1_row_reg == row_dn)) begin
                down_reg <= total;
            end else begin
                down_reg <= col_mem[row_dn];
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_best_total = m_best_reg;

endmodule

// ===== hw/rtl/gmp_checker.sv =====
// Port-level checks for the grid maximum path block, bound to its top level.
module gmp_checker #(
    parameter int CELL_BITS = gmp_pkg::DEF_CELL_BITS
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [CELL_BITS-1:0]        s_cell_value,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [gmp_pkg::TOTAL_W-1:0] m_best_total
);
    // A waiting result item holds its value until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_best_total))
        else $error("result item changed while stalled");

    // A waiting input item holds its value until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_cell_value))
        else $error("input item changed while stalled");

    // Input backpressure only ever comes from a stalled result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a stalled result");

    // A new result item follows the accept of its last cell through the second stage and the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result item without a matching cell");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind grid_max_path_dp gmp_checker #(.CELL_BITS(CELL_BITS)) u_gmp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_cell_value (s_cell_value),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_best_total (m_best_total)
);
